### hdl/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants of the segment point discretizer.
// ----------------------------------------------------------------------------
package spd_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W        = 32;
	localparam int MAG_W          = COORD_W + 1;
	localparam int AXES           = 3;
	localparam int SQ_PRODUCTS    = 9;
	localparam int SQRT_STEPS     = 33;
	localparam int DIV_STEPS      = 35;
	localparam int BDIV_STEPS     = MAG_W;
	localparam logic [31:0] STEP_RESET = 32'd65536;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SQ,
		F_SQRT,
		F_PREP,
		F_DIV,
		F_CLAMP,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_EMIT
	} back_state_t;

	// one classified segment travelling from front to back
	typedef struct packed {
		logic [AXES-1:0][COORD_W-1:0] s;
		logic [AXES-1:0][MAG_W-1:0]   m;
		logic [AXES-1:0]              neg;
		logic                         clamped;
	} seg_t;

endpackage

### hdl/spd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_fifo
// Two-entry queue between the front and the back part.
// ----------------------------------------------------------------------------
module spd_fifo import spd_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	logic [1:0][WIDTH-1:0] mem_q;
	logic                  wr_q;
	logic                  rd_q;
	logic [1:0]            cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### hdl/spd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_front
// Accepts a segment, works out its length and the number of points.
// ----------------------------------------------------------------------------
module spd_front import spd_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int NW = $clog2(MAX_POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] stop_x,
	input  logic signed [31:0] stop_y,
	input  logic signed [31:0] stop_z,
	input  logic [31:0]        step_len,
	output logic               push,
	input  logic               push_full,
	output seg_t               push_seg,
	output logic [NW-1:0]      push_n
);

	front_state_t state_q, state_d;

	logic [AXES-1:0][COORD_W-1:0] s_q;
	logic [AXES-1:0][MAG_W-1:0]   m_q;
	logic [AXES-1:0]              neg_q;
	logic                         clamped_q;
	logic [NW-1:0]                count_q;

	logic [1:0]  axis_q;
	logic [1:0]  part_q;
	logic [1:0]  ptag_q;
	logic [33:0] prod_q;
	logic [65:0] sum_q;
	logic [32:0] root_q;
	logic [33:0] rem_q;
	logic [34:0] dvd_q;
	logic [32:0] dvs_q;
	logic [34:0] quo_q;
	logic [32:0] drem_q;
	logic [5:0]  cnt_q;

	logic                         accept;
	logic [AXES-1:0][COORD_W-1:0] in_start;
	logic [AXES-1:0][COORD_W-1:0] in_stop;
	logic [AXES-1:0][MAG_W-1:0]   in_mag;
	logic [AXES-1:0]              in_neg;
	logic [16:0]                  mul_a;
	logic [16:0]                  mul_b;
	logic [65:0]                  prod_sh;
	logic [35:0]                  rem_w;
	logic [35:0]                  trial;
	logic [33:0]                  drem_w;
	logic                         sq_last;

	assign accept = seg_valid && !seg_stall;
	assign in_start = {start_z, start_y, start_x};
	assign in_stop  = {stop_z, stop_y, stop_x};

	always_comb begin
		logic [MAG_W-1:0] d;
		for (int k = 0; k < AXES; k++) begin
			d = {in_stop[k][COORD_W-1], in_stop[k]} - {in_start[k][COORD_W-1], in_start[k]};
			in_neg[k] = d[MAG_W-1];
			in_mag[k] = d[MAG_W-1] ? (~d + 1'b1) : d;
		end
	end

	// square of each magnitude from three 17 x 17 partial products
	always_comb begin
		unique case (part_q)
			2'd0: begin
				mul_a = {1'b0, m_q[axis_q][15:0]};
				mul_b = {1'b0, m_q[axis_q][15:0]};
			end
			2'd1: begin
				mul_a = m_q[axis_q][32:16];
				mul_b = {1'b0, m_q[axis_q][15:0]};
			end
			default: begin
				mul_a = m_q[axis_q][32:16];
				mul_b = m_q[axis_q][32:16];
			end
		endcase
	end

	always_comb begin
		unique case (ptag_q)
			2'd0:    prod_sh = {32'd0, prod_q};
			2'd1:    prod_sh = {15'd0, prod_q, 17'd0};
			default: prod_sh = {prod_q, 32'd0};
		endcase
	end

	assign sq_last = (cnt_q == 6'(SQ_PRODUCTS));
	assign rem_w   = {rem_q, sum_q[65:64]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign drem_w  = {drem_q, dvd_q[34]};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (seg_valid) state_d = F_SQ;
			F_SQ:    if (sq_last) state_d = F_SQRT;
			F_SQRT:  if (cnt_q == 6'(SQRT_STEPS - 1)) state_d = F_PREP;
			F_PREP: begin
				if ((root_q > {1'b0, step_len}) && (step_len != 32'd0)) begin
					state_d = F_DIV;
				end else begin
					state_d = F_PUSH;
				end
			end
			F_DIV:   if (cnt_q == 6'(DIV_STEPS - 1)) state_d = F_CLAMP;
			F_CLAMP: state_d = F_PUSH;
			F_PUSH:  if (!push_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		seg_stall = (state_q != F_IDLE);
		push      = (state_q == F_PUSH);
	end

	assign push_seg = '{s: s_q, m: m_q, neg: neg_q, clamped: clamped_q};
	assign push_n   = count_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (accept) begin
					s_q    <= in_start;
					m_q    <= in_mag;
					neg_q  <= in_neg;
					axis_q <= 2'd0;
					part_q <= 2'd0;
					cnt_q  <= 6'd0;
					sum_q  <= '0;
				end
			end
			F_SQ: begin
				if (!sq_last) begin
					prod_q <= mul_a * mul_b;
					ptag_q <= part_q;
					if (part_q == 2'd2) begin
						part_q <= 2'd0;
						axis_q <= axis_q + 2'd1;
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				if (cnt_q != 6'd0) begin
					sum_q <= sum_q + prod_sh;
				end
				if (sq_last) begin
					cnt_q  <= 6'd0;
					root_q <= '0;
					rem_q  <= '0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
			F_SQRT: begin
				// one result bit per step, two radicand bits in
				if (rem_w >= trial) begin
					rem_q  <= 34'(rem_w - trial);
					root_q <= {root_q[31:0], 1'b1};
				end else begin
					rem_q  <= rem_w[33:0];
					root_q <= {root_q[31:0], 1'b0};
				end
				sum_q <= {sum_q[63:0], 2'b00};
				cnt_q <= cnt_q + 6'd1;
			end
			F_PREP: begin
				clamped_q <= 1'b0;
				count_q   <= '0;
				if (root_q > {1'b0, step_len}) begin
					if (step_len == 32'd0) begin
						clamped_q <= 1'b1;
						count_q   <= NW'(MAX_POINTS - 2);
					end
				end
				dvd_q  <= {1'b0, root_q, 1'b0} + {3'd0, step_len};
				dvs_q  <= {step_len, 1'b0};
				drem_q <= '0;
				quo_q  <= '0;
				cnt_q  <= 6'd0;
			end
			F_DIV: begin
				if (drem_w >= {1'b0, dvs_q}) begin
					drem_q <= 33'(drem_w - {1'b0, dvs_q});
					quo_q  <= {quo_q[33:0], 1'b1};
				end else begin
					drem_q <= drem_w[32:0];
					quo_q  <= {quo_q[33:0], 1'b0};
				end
				dvd_q <= {dvd_q[33:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			F_CLAMP: begin
				if (quo_q > 35'(MAX_POINTS - 2)) begin
					clamped_q <= 1'b1;
					count_q   <= NW'(MAX_POINTS - 2);
				end else begin
					count_q <= quo_q[NW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/spd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_back
// Takes a classified segment and steps out its evenly spaced points.
// ----------------------------------------------------------------------------
module spd_back import spd_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	localparam int NW = $clog2(MAX_POINTS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  seg_t               pop_seg,
	input  logic [NW-1:0]      pop_n,
	output logic               pop,
	output logic               pt_valid,
	input  logic               pt_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic               last_point,
	output logic               count_clamped
);

	back_state_t state_q, state_d;

	logic [AXES-1:0][COORD_W-1:0] s_q;
	logic [AXES-1:0][MAG_W-1:0]   m_q;
	logic [AXES-1:0]              neg_q;
	logic                         clamped_q;
	logic [NW-1:0]                n_q;
	logic [AXES-1:0][MAG_W-1:0]   a_q;
	logic [AXES-1:0][NW-1:0]      dr_q;
	logic [AXES-1:0][MAG_W-1:0]   q_q;
	logic [AXES-1:0][NW:0]        r_q;
	logic [NW-1:0]                i_q;
	logic [5:0]                   cnt_q;

	logic                         ovalid_q;
	logic [AXES-1:0][COORD_W-1:0] pt_q;
	logic                         last_q;
	logic                         clamp_out_q;

	logic                         slot_free;
	logic                         emit;
	logic                         is_last;
	logic [AXES-1:0][NW:0]        dw;
	logic [AXES-1:0]              dge;
	logic [AXES-1:0][COORD_W-1:0] pt_d;
	logic [AXES-1:0][NW+1:0]      rs;
	logic [AXES-1:0]              rge;
	logic [NW+1:0]                n2;

	assign slot_free = !ovalid_q || !pt_stall;
	assign is_last   = (i_q == n_q);
	assign n2        = {1'b0, n_q, 1'b0};

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			dw[k]  = {dr_q[k], m_q[k][MAG_W-1]};
			dge[k] = dw[k] >= {1'b0, n_q};
			// offset of this point, applied with the sign of the difference
			pt_d[k] = neg_q[k] ? (s_q[k] - q_q[k][COORD_W-1:0])
			                   : (s_q[k] + q_q[k][COORD_W-1:0]);
			rs[k]  = {1'b0, r_q[k]} + {1'b0, dr_q[k], 1'b0};
			rge[k] = rs[k] >= n2;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (pop_valid) state_d = B_DIV;
			B_DIV:  if (cnt_q == 6'(BDIV_STEPS - 1)) state_d = B_EMIT;
			B_EMIT: if (slot_free && is_last) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop  = (state_q == B_IDLE) && pop_valid;
		emit = (state_q == B_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (slot_free) begin
				ovalid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pt_q        <= pt_d;
			last_q      <= is_last;
			clamp_out_q <= clamped_q;
		end
		unique case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					s_q       <= pop_seg.s;
					m_q       <= pop_seg.m;
					neg_q     <= pop_seg.neg;
					clamped_q <= pop_seg.clamped;
					n_q       <= pop_n;
					dr_q      <= '0;
					a_q       <= '0;
					cnt_q     <= 6'd0;
				end
			end
			B_DIV: begin
				// magnitude over point spacing count, one quotient bit per lane
				for (int k = 0; k < AXES; k++) begin
					if (dge[k]) begin
						dr_q[k] <= NW'(dw[k] - {1'b0, n_q});
					end else begin
						dr_q[k] <= dw[k][NW-1:0];
					end
					a_q[k] <= {a_q[k][MAG_W-2:0], dge[k]};
					m_q[k] <= {m_q[k][MAG_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(BDIV_STEPS - 1)) begin
					for (int k = 0; k < AXES; k++) begin
						q_q[k] <= '0;
						r_q[k] <= {1'b0, n_q};
					end
					i_q <= '0;
				end
			end
			B_EMIT: begin
				if (emit) begin
					for (int k = 0; k < AXES; k++) begin
						if (rge[k]) begin
							r_q[k] <= (NW+1)'(rs[k] - n2);
							q_q[k] <= q_q[k] + a_q[k] + 1'b1;
						end else begin
							r_q[k] <= rs[k][NW:0];
							q_q[k] <= q_q[k] + a_q[k];
						end
					end
					i_q <= i_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign pt_valid      = ovalid_q;
	assign point_x       = pt_q[0];
	assign point_y       = pt_q[1];
	assign point_z       = pt_q[2];
	assign last_point    = last_q;
	assign count_clamped = clamp_out_q;

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> (i_q <= n_q))
		else $error("point index beyond segment end");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == B_DIV))
		else $error("segment taken without starting division");

	a_residue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> ({1'b0, r_q[0]} < n2))
		else $error("rounding residue out of range");

	a_last_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_last) |=> (state_q == B_IDLE) && pt_valid && last_point)
		else $error("last point not closing the segment");

endmodule

### hdl/segment_point_discretizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_point_discretizer
// Splits a 3D segment into evenly spaced Q16.16 points, start and stop
// included.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  segment   in         seg_valid/seg_stall  start_x..z, stop_x..z
//  point     out        pt_valid/pt_stall    point_x..z, last_point, count_clamped
//  config    in         cfg_valid/cfg_ready  step_length
//
//  front: per segment 9 partial squares, a 33-step square root and a 35-step
//  division, the division skipped when it is not needed; the item then waits in
//  a two-entry queue.
//  back: a per-axis division, then one point a cycle while the output is not
//  stalled.
//  the front is taken up by the next segment while the back emits.
//  arst_n clears all control; step_length returns to 1.0.
//  a stalled point holds in the output register while the back waits.
// ----------------------------------------------------------------------------
module segment_point_discretizer import spd_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seg_valid,
	output logic               seg_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] stop_x,
	input  logic signed [31:0] stop_y,
	input  logic signed [31:0] stop_z,
	output logic               pt_valid,
	input  logic               pt_stall,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic               last_point,
	output logic               count_clamped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        step_length
);

	localparam int NW = $clog2(MAX_POINTS);

	logic [31:0]   step_q;
	logic          push;
	logic          full;
	seg_t          push_seg;
	logic [NW-1:0] push_n;
	logic          pop;
	logic          not_empty;
	seg_t          pop_seg;
	logic [NW-1:0] pop_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			step_q <= step_length;
		end
	end

	spd_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.start_x   (start_x),
		.start_y   (start_y),
		.start_z   (start_z),
		.stop_x    (stop_x),
		.stop_y    (stop_y),
		.stop_z    (stop_z),
		.step_len  (step_q),
		.push      (push),
		.push_full (full),
		.push_seg  (push_seg),
		.push_n    (push_n)
	);

	spd_fifo #(.WIDTH($bits(seg_t) + NW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_seg, push_n}),
		.full      (full),
		.pop       (pop),
		.pop_data  ({pop_seg, pop_n}),
		.not_empty (not_empty)
	);

	spd_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (not_empty),
		.pop_seg       (pop_seg),
		.pop_n         (pop_n),
		.pop           (pop),
		.pt_valid      (pt_valid),
		.pt_stall      (pt_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.last_point    (last_point),
		.count_clamped (count_clamped)
	);

endmodule
